@@ design/assert_macros.svh @@
// Assertion macros used by gait_phase_state_machine.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication check, sampled on the rising clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ design/gpsm_pkg.sv @@
// Types, constants and helper functions of the gait phase state machine.
// No dependencies.
package gpsm_pkg;

    // Gait phases
    typedef enum logic [3:0] {
        PH_IDLE            = 4'd0,
        PH_PRE_SWING       = 4'd1,
        PH_INITIAL_SWING   = 4'd2,
        PH_MID_SWING       = 4'd3,
        PH_TERMINAL_SWING  = 4'd4,
        PH_LOADING         = 4'd5,
        PH_MID_STANCE      = 4'd6,
        PH_TERMINAL_STANCE = 4'd7,
        PH_PRE_SWING_STANCE = 4'd8
    } gait_phase_t;

    // Input transaction
    typedef struct packed {
        logic [15:0] speed_mag;
        logic [15:0] press_sum;
        logic [31:0] time_ms;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [3:0]  phase_now;
        logic [3:0]  phase_before;
        logic        changed;
        logic [31:0] time_in_phase;
        logic [14:0] phase_pct;
    } out_item_t;

    localparam logic [15:0] VLIMIT_DEFAULT = 16'd26;
    localparam logic [14:0] PCT_FULL       = 15'd25600;

    // Pressure and time thresholds
    localparam logic [15:0] PRESS_LIFT   = 16'd100;
    localparam logic [15:0] PRESS_LOAD   = 16'd500;
    localparam logic [15:0] PRESS_UNLOAD = 16'd300;
    localparam logic [31:0] DUR_SWING    = 32'd100;
    localparam logic [31:0] DUR_LOADING  = 32'd50;

    // Reciprocal of 3 for x < 2^19: floor(x/3) = (x * DIV3_RECIP) >> DIV3_SHIFT
    localparam logic [18:0] DIV3_RECIP = 19'd349526;
    localparam int          DIV3_SHIFT = 20;

    // Typical phase duration in ms; zero for idle and unused codes
    function automatic logic [7:0] typical_ms(input gait_phase_t ph);
        logic [7:0] t;
        unique case (ph)
            PH_PRE_SWING:        t = 8'd50;
            PH_INITIAL_SWING:    t = 8'd100;
            PH_MID_SWING:        t = 8'd150;
            PH_TERMINAL_SWING:   t = 8'd100;
            PH_LOADING:          t = 8'd100;
            PH_MID_STANCE:       t = 8'd200;
            PH_TERMINAL_STANCE:  t = 8'd100;
            PH_PRE_SWING_STANCE: t = 8'd50;
            default:             t = 8'd0;
        endcase
        return t;
    endfunction

endpackage

@@ design/gait_phase_state_machine.sv @@
// Gait phase state machine: input register, one pass of phase and percentage
// logic, result register. Depends on gpsm_pkg and assert_macros.svh.
//
// Throughput: 1 transaction per cycle; the single-pass phase update between the
// input and result registers sets it. A stalled result holds both stages.
// Reset: phase, prior phase, entry time and percentage clear to 0; the velocity
// limit returns to 26 (about 0.1 m/s).
`include "assert_macros.svh"

module gait_phase_state_machine
    import gpsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic        s1_valid_reg;
    in_item_t    s1_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic [15:0] vlimit_reg;
    gait_phase_t phase_reg, phase_next;
    gait_phase_t prior_phase_reg, prior_phase_next;
    logic [31:0] entry_time_reg, entry_time_next;
    logic [14:0] pct_reg, pct_next;

    logic        s1_adv;
    logic        s1_fire;
    logic [15:0] lim;
    logic [31:0] dur_raw;
    logic [31:0] dur;
    logic        changed;
    logic [7:0]  typ;
    logic [16:0] div3_num;
    logic [35:0] div3_prod;
    out_item_t   res_next;

    // Pipeline handshake
    assign s1_adv   = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;

    // Velocity limit register; zero acts as the default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vlimit_reg <= VLIMIT_DEFAULT;
        else if (cfg_wr_en)
            vlimit_reg <= cfg_wr_data;
    end

    assign lim     = (vlimit_reg == 16'd0) ? VLIMIT_DEFAULT : vlimit_reg;
    assign dur_raw = s1_data_reg.time_ms - entry_time_reg;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
                if (s1_data_reg.speed_mag > lim) phase_next = PH_PRE_SWING;
            PH_PRE_SWING:
                if (s1_data_reg.press_sum < PRESS_LIFT) phase_next = PH_INITIAL_SWING;
            PH_INITIAL_SWING:
                if (dur_raw > DUR_SWING) phase_next = PH_MID_SWING;
            PH_MID_SWING:
                if ({1'b0, s1_data_reg.speed_mag} < {lim, 1'b0})
                    phase_next = PH_TERMINAL_SWING;
            PH_TERMINAL_SWING:
                if (s1_data_reg.press_sum > PRESS_LIFT) phase_next = PH_LOADING;
            PH_LOADING:
                if (s1_data_reg.press_sum > PRESS_LOAD && dur_raw > DUR_LOADING)
                    phase_next = PH_MID_STANCE;
            PH_MID_STANCE:
                if (s1_data_reg.speed_mag < lim) phase_next = PH_TERMINAL_STANCE;
            PH_TERMINAL_STANCE:
                if (s1_data_reg.press_sum < PRESS_UNLOAD)
                    phase_next = PH_PRE_SWING_STANCE;
            PH_PRE_SWING_STANCE:
                if (s1_data_reg.press_sum < PRESS_LIFT) phase_next = PH_PRE_SWING;
            default:
                phase_next = phase_reg;
        endcase
    end

    // Transition bookkeeping and percentage
    assign changed   = (phase_next != phase_reg);
    assign dur       = changed ? 32'd0 : dur_raw;
    assign typ       = typical_ms(phase_next);
    assign div3_num  = {dur[7:0], 9'd0};
    assign div3_prod = {19'd0, div3_num} * {17'd0, DIV3_RECIP};

    always_comb
    begin
        prior_phase_next = changed ? phase_reg : prior_phase_reg;
        entry_time_next  = changed ? s1_data_reg.time_ms : entry_time_reg;
        pct_next         = pct_reg;
        if (typ != 8'd0)
        begin
            if (dur >= {24'd0, typ})
                pct_next = PCT_FULL;
            else
            begin
                case (typ)
                    8'd50:   pct_next = {dur[5:0], 9'd0};
                    8'd100:  pct_next = {dur[6:0], 8'd0};
                    8'd200:  pct_next = {dur[7:0], 7'd0};
                    default: pct_next = div3_prod[DIV3_SHIFT +: 15];
                endcase
            end
        end
    end

    // Assemble the result
    always_comb
    begin
        res_next.phase_now     = phase_next;
        res_next.phase_before  = prior_phase_next;
        res_next.changed       = changed;
        res_next.time_in_phase = dur;
        res_next.phase_pct     = pct_next;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
    end

    // Advance state on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            prior_phase_reg <= PH_IDLE;
            entry_time_reg  <= 32'd0;
            pct_reg         <= 15'd0;
        end
        else if (s1_fire)
        begin
            phase_reg       <= phase_next;
            prior_phase_reg <= prior_phase_next;
            entry_time_reg  <= entry_time_next;
            pct_reg         <= pct_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_data_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `ASSERT_IMPL(a_change_clears_dur, clk, rst_n,
        out_valid_reg && out_data_reg.changed |-> out_data_reg.time_in_phase == 32'd0,
        "transition result carries nonzero time in phase")
    `ASSERT_IMPL(a_change_differs, clk, rst_n,
        out_valid_reg && out_data_reg.changed |->
            out_data_reg.phase_now != out_data_reg.phase_before,
        "transition result with equal current and prior phase")
    `ASSERT_NEVER(a_pct_cap, clk, rst_n, pct_reg > PCT_FULL,
        "phase percentage above full scale")
    `ASSERT_IMPL(a_stall_holds_state, clk, rst_n,
        out_valid_reg && !out_ready |=> $stable(phase_reg) && $stable(entry_time_reg),
        "phase state moved while result stalled")

endmodule
